// ----- design/cd_toc_offset_builder_top_macros.svh -----
// Assertion macros used by the checker file of the TOC offset builder.
`ifndef CD_TOC_OFFSET_BUILDER_TOP_MACROS_SVH
`define CD_TOC_OFFSET_BUILDER_TOP_MACROS_SVH

// Check a property at every clock edge, reset included.
`define CDTOC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("cdtoc check failed");

// Check a property only while the block is out of reset.
`define CDTOC_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cdtoc check failed");

`endif

// ----- design/cdtoc_pkg.sv -----
// Package with types, codes and constants of the CD TOC offset builder.
package cdtoc_pkg;

    // Field widths fixed by the item format
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 7;
    localparam int CTRL_W   = 4;
    localparam int ADDR_W   = 19;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 21;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EVAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FIRST = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LAST  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_AUDIO  = 2'd3;

    // Control nibble bit that marks a data track
    localparam int DATA_BIT = 2;

    // Frame constants: lead-in and the gap before a data session
    localparam int LEAD_IN = 150;
    localparam int XA_GAP  = (60 + 90 + 2) * 75;
    localparam logic signed [OFF_W-1:0] LEAD_IN_OFF = OFF_W'(LEAD_IN);
    localparam logic signed [OFF_W-1:0] GAP_ADJ     = OFF_W'(XA_GAP - LEAD_IN);

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LEAD_EV,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FINISH
    } t_state;

endpackage

// ----- design/cd_toc_offset_builder_top.sv -----
// Top level of the CD TOC offset builder: entry memory, offset memory, controller.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  input   | in        | i_valid / o_ready  | func, slot, control_bits, start_address,
//          |           |                    | first_track, last_track
//  result  | out       | o_valid / i_ready  | status, first_audio, last_audio, offset
//
// Load and unused codes are answered from the idle state; read goes through the registered
// offset memory read. Evaluate steps through the slots scanned and the slots walked, and
// every slot step goes through the single read port of the entry memory.
// Reset needs no clearing pass: the valid flags stand for the cleared offset table.
// A result goes to a pending register and then the output register, so a stalled output
// holds one result while the next item is taken.
module cd_toc_offset_builder_top #(
    parameter int TRACK_SLOTS  = 100,
    parameter int ADDRESS_BITS = 19
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [cdtoc_pkg::FUNC_W-1:0]          i_func,
    input  logic [cdtoc_pkg::SLOT_W-1:0]          i_slot,
    input  logic [cdtoc_pkg::CTRL_W-1:0]          i_control_bits,
    input  logic [cdtoc_pkg::ADDR_W-1:0]          i_start_address,
    input  logic [cdtoc_pkg::SLOT_W-1:0]          i_first_track,
    input  logic [cdtoc_pkg::SLOT_W-1:0]          i_last_track,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [cdtoc_pkg::STATUS_W-1:0]        o_status,
    output logic [cdtoc_pkg::SLOT_W-1:0]          o_first_audio,
    output logic [cdtoc_pkg::SLOT_W-1:0]          o_last_audio,
    output logic signed [cdtoc_pkg::OFF_W-1:0]    o_offset
);

    localparam int IdxW  = $clog2(TRACK_SLOTS);
    localparam int AddrW = (ADDRESS_BITS < cdtoc_pkg::ADDR_W) ? ADDRESS_BITS
                                                              : cdtoc_pkg::ADDR_W;
    localparam int EntW  = cdtoc_pkg::CTRL_W + AddrW;
    localparam logic [cdtoc_pkg::SLOT_W:0] SlotsL = (cdtoc_pkg::SLOT_W + 1)'(TRACK_SLOTS);

    // Memories: control and address per slot, offset per slot
    logic [EntW-1:0]                       mem_entry [TRACK_SLOTS];
    logic signed [cdtoc_pkg::OFF_W-1:0]    mem_off   [TRACK_SLOTS];
    logic [EntW-1:0]                       r_ent_q;
    logic signed [cdtoc_pkg::OFF_W-1:0]    r_off_q;
    logic [TRACK_SLOTS-1:0]                r_valid;

    // Controller registers
    cdtoc_pkg::t_state                     r_state, n_state;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_idx, n_idx;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_first, n_first;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_last, n_last;
    logic signed [cdtoc_pkg::OFF_W-1:0]    r_lead, n_lead;
    logic [AddrW-1:0]                      r_prev_addr, n_prev_addr;
    logic                                  r_dropping, n_dropping;
    logic                                  r_slot_ok, n_slot_ok;
    logic [cdtoc_pkg::STATUS_W-1:0]        r_status, n_status;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_first_audio, n_first_audio;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_last_audio, n_last_audio;

    // Pending result and output register
    logic                                  r_res_valid, n_res_valid;
    logic [cdtoc_pkg::STATUS_W-1:0]        r_res_status;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_res_first, r_res_last;
    logic signed [cdtoc_pkg::OFF_W-1:0]    r_res_offset, res_offset;
    logic                                  r_out_valid;
    logic [cdtoc_pkg::STATUS_W-1:0]        r_out_status;
    logic [cdtoc_pkg::SLOT_W-1:0]          r_out_first, r_out_last;
    logic signed [cdtoc_pkg::OFF_W-1:0]    r_out_offset;

    // Memory controls
    logic                                  ent_we, ent_re;
    logic [IdxW-1:0]                       ent_raddr;
    logic                                  off_we, off_re;
    logic [IdxW-1:0]                       off_waddr, off_raddr;
    logic signed [cdtoc_pkg::OFF_W-1:0]    off_wdata;
    logic                                  valid_clr;
    logic                                  produce;

    // Datapath helpers
    logic                                  accept, out_free, slot_in_range;
    logic                                  first_bad, last_bad;
    logic [AddrW-1:0]                      ent_addr;
    logic                                  ent_is_data;
    logic signed [cdtoc_pkg::OFF_W-1:0]    ent_off, ent_gap, prev_gap, keep_off;

    assign out_free      = !r_out_valid || i_ready;
    assign o_ready       = (r_state == cdtoc_pkg::ST_IDLE) && (!r_res_valid || out_free);
    assign accept        = i_valid && o_ready;
    assign slot_in_range = {1'b0, i_slot} < SlotsL;
    assign first_bad     = (i_first_track == '0) || ({1'b0, i_first_track} >= SlotsL);
    assign last_bad      = (i_last_track == '0) || ({1'b0, i_last_track} >= SlotsL);

    assign ent_addr    = r_ent_q[AddrW-1:0];
    assign ent_is_data = r_ent_q[AddrW + cdtoc_pkg::DATA_BIT];
    assign ent_off     = $signed(cdtoc_pkg::OFF_W'(ent_addr)) + cdtoc_pkg::LEAD_IN_OFF;
    assign ent_gap     = $signed(cdtoc_pkg::OFF_W'(ent_addr)) - cdtoc_pkg::GAP_ADJ;
    assign prev_gap    = $signed(cdtoc_pkg::OFF_W'(r_prev_addr)) - cdtoc_pkg::GAP_ADJ;
    assign keep_off    = (r_idx >= r_first) ? ent_off : '0;

    // Entry memory: written by loads, read during evaluate only
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_entry[i_slot[IdxW-1:0]] <= {i_control_bits, i_start_address[AddrW-1:0]};
        end
        if (ent_re) begin
            r_ent_q <= mem_entry[ent_raddr];
        end
    end

    // Offset memory: written by evaluate, read by offset reads
    always_ff @(posedge i_clk) begin
        if (off_we) begin
            mem_off[off_waddr] <= off_wdata;
        end
        if (off_re) begin
            r_off_q <= mem_off[off_raddr];
        end
    end

    // Next state, memory controls and results
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_first       = r_first;
        n_last        = r_last;
        n_lead        = r_lead;
        n_prev_addr   = r_prev_addr;
        n_dropping    = r_dropping;
        n_slot_ok     = r_slot_ok;
        n_status      = r_status;
        n_first_audio = r_first_audio;
        n_last_audio  = r_last_audio;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        ent_raddr     = r_idx[IdxW-1:0];
        off_we        = 1'b0;
        off_re        = 1'b0;
        off_waddr     = r_idx[IdxW-1:0];
        off_raddr     = i_slot[IdxW-1:0];
        off_wdata     = '0;
        valid_clr     = 1'b0;
        produce       = 1'b0;
        res_offset    = '0;

        unique case (r_state)
            cdtoc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        cdtoc_pkg::FUNC_LOAD: begin
                            ent_we  = slot_in_range;
                            produce = 1'b1;
                        end
                        cdtoc_pkg::FUNC_EVAL: begin
                            // clear the table and the audio range, then check the bounds
                            valid_clr     = 1'b1;
                            n_first_audio = '0;
                            n_last_audio  = '0;
                            n_first       = i_first_track;
                            n_last        = i_last_track;
                            if (first_bad) begin
                                n_status = cdtoc_pkg::STATUS_BAD_FIRST;
                                produce  = 1'b1;
                            end else if (last_bad) begin
                                n_status = cdtoc_pkg::STATUS_BAD_LAST;
                                produce  = 1'b1;
                            end else begin
                                ent_re    = 1'b1;
                                ent_raddr = '0;
                                n_state   = cdtoc_pkg::ST_LEAD_EV;
                            end
                        end
                        cdtoc_pkg::FUNC_READ: begin
                            off_re    = 1'b1;
                            n_slot_ok = slot_in_range;
                            n_idx     = i_slot;
                            n_state   = cdtoc_pkg::ST_READ;
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            cdtoc_pkg::ST_READ: begin
                // never-written table entries read as zero through the valid flags
                if (r_slot_ok && r_valid[r_idx[IdxW-1:0]]) begin
                    res_offset = r_off_q;
                end
                produce = 1'b1;
                n_state = cdtoc_pkg::ST_IDLE;
            end
            cdtoc_pkg::ST_LEAD_EV: begin
                // regular lead-out offset, then scan down from the last track
                n_lead = ent_off;
                n_idx  = r_last;
                if (r_first > r_last) begin
                    n_status = cdtoc_pkg::STATUS_NO_AUDIO;
                    produce  = 1'b1;
                    n_state  = cdtoc_pkg::ST_IDLE;
                end else begin
                    n_state = cdtoc_pkg::ST_SCAN_RD;
                end
            end
            cdtoc_pkg::ST_SCAN_RD: begin
                ent_re  = 1'b1;
                n_state = cdtoc_pkg::ST_SCAN_EV;
            end
            cdtoc_pkg::ST_SCAN_EV: begin
                if (!ent_is_data) begin
                    // last audio track found; a data track above it moves the lead-out
                    if (r_idx != r_last) begin
                        n_lead = prev_gap;
                    end
                    n_dropping = 1'b1;
                    n_state    = cdtoc_pkg::ST_WALK_EV;
                end else begin
                    n_prev_addr = ent_addr;
                    if (r_idx == r_first) begin
                        n_status = cdtoc_pkg::STATUS_NO_AUDIO;
                        produce  = 1'b1;
                        n_state  = cdtoc_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = cdtoc_pkg::ST_SCAN_RD;
                    end
                end
            end
            cdtoc_pkg::ST_WALK_RD: begin
                ent_re  = 1'b1;
                n_state = cdtoc_pkg::ST_WALK_EV;
            end
            cdtoc_pkg::ST_WALK_EV: begin
                if (r_dropping && (r_lead < keep_off)) begin
                    // drop this track: its offset stays clear, lead-out moves below it
                    n_lead = ent_gap;
                    if (r_idx == 7'd1) begin
                        n_state = cdtoc_pkg::ST_FINISH;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = cdtoc_pkg::ST_WALK_RD;
                    end
                end else begin
                    // keep this track and write offsets down to the first track
                    if (r_dropping) begin
                        n_last_audio = r_idx;
                    end
                    n_dropping = 1'b0;
                    if (r_idx >= r_first) begin
                        off_we    = 1'b1;
                        off_wdata = ent_off;
                    end
                    if (r_idx <= r_first) begin
                        n_state = cdtoc_pkg::ST_FINISH;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = cdtoc_pkg::ST_WALK_RD;
                    end
                end
            end
            cdtoc_pkg::ST_FINISH: begin
                // store the lead-out and publish the audio range
                off_we        = 1'b1;
                off_waddr     = '0;
                off_wdata     = r_lead;
                n_status      = cdtoc_pkg::STATUS_OK;
                n_first_audio = r_first;
                produce       = 1'b1;
                n_state       = cdtoc_pkg::ST_IDLE;
            end
            default: begin
                n_state = cdtoc_pkg::ST_IDLE;
            end
        endcase

        // Hold a produced item until the output register frees up
        if (produce) begin
            n_res_valid = 1'b1;
        end else if (r_res_valid && out_free) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    // State register and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cdtoc_pkg::ST_IDLE;
            r_dropping    <= 1'b0;
            r_status      <= cdtoc_pkg::STATUS_OK;
            r_first_audio <= '0;
            r_last_audio  <= '0;
            r_res_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_valid       <= '0;
        end else begin
            r_state       <= n_state;
            r_dropping    <= n_dropping;
            r_status      <= n_status;
            r_first_audio <= n_first_audio;
            r_last_audio  <= n_last_audio;
            r_res_valid   <= n_res_valid;
            if (r_res_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (valid_clr) begin
                r_valid <= '0;
            end else if (off_we) begin
                r_valid[off_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_first     <= n_first;
        r_last      <= n_last;
        r_lead      <= n_lead;
        r_prev_addr <= n_prev_addr;
        r_slot_ok   <= n_slot_ok;
        if (produce) begin
            r_res_status <= n_status;
            r_res_first  <= n_first_audio;
            r_res_last   <= n_last_audio;
            r_res_offset <= res_offset;
        end
        if (r_res_valid && out_free) begin
            r_out_status <= r_res_status;
            r_out_first  <= r_res_first;
            r_out_last   <= r_res_last;
            r_out_offset <= r_res_offset;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_audio = r_out_first;
    assign o_last_audio  = r_out_last;
    assign o_offset      = r_out_offset;

endmodule

// ----- design/cdtoc_checker.sv -----
// Port checker of the CD TOC offset builder and its bind to the top level.
`include "cd_toc_offset_builder_top_macros.svh"

module cdtoc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [cdtoc_pkg::FUNC_W-1:0]        i_func,
    input logic [cdtoc_pkg::SLOT_W-1:0]        i_slot,
    input logic [cdtoc_pkg::CTRL_W-1:0]        i_control_bits,
    input logic [cdtoc_pkg::ADDR_W-1:0]        i_start_address,
    input logic [cdtoc_pkg::SLOT_W-1:0]        i_first_track,
    input logic [cdtoc_pkg::SLOT_W-1:0]        i_last_track,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [cdtoc_pkg::STATUS_W-1:0]      o_status,
    input logic [cdtoc_pkg::SLOT_W-1:0]        o_first_audio,
    input logic [cdtoc_pkg::SLOT_W-1:0]        o_last_audio,
    input logic signed [cdtoc_pkg::OFF_W-1:0]  o_offset
);

    // A waiting input item keeps its valid and payload
    property p_in_hold;
        i_valid && !o_ready |=> i_valid && $stable(i_func) && $stable(i_slot)
            && $stable(i_control_bits) && $stable(i_start_address)
            && $stable(i_first_track) && $stable(i_last_track);
    endproperty

    // A stalled result keeps its valid, offset, status and last audio track
    property p_out_hold;
        o_valid && !i_ready |=> o_valid && $stable(o_offset) && $stable(o_status)
            && $stable(o_last_audio);
    endproperty

    // Without a good evaluation the offset table reads as clear
    property p_offset_clear;
        o_valid && (o_status != cdtoc_pkg::STATUS_OK || o_first_audio == '0)
            |-> o_offset == '0;
    endproperty

    // Reset empties the output register
    `CDTOC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

    // Hold the input item until it is taken
    `CDTOC_ASSERT_RUN(a_in_hold, p_in_hold)

    // A stalled item holds its offset, status and last audio track
    `CDTOC_ASSERT_RUN(a_out_hold, p_out_hold)

    // No first audio track means no audio range at all
    `CDTOC_ASSERT_RUN(a_range_empty, o_valid && o_first_audio == '0 |-> o_last_audio == '0)

    // Clear offsets outside a good evaluation
    `CDTOC_ASSERT_RUN(a_offset_clear, p_offset_clear)

endmodule

bind cd_toc_offset_builder_top cdtoc_checker u_cdtoc_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the CD TOC offset builder: directed cases and random disc layouts against a predictor.
package tb_toc_pkg;
    import cdtoc_pkg::*;

    localparam int TOC_SLOTS = 100;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       first_audio;
        logic [SLOT_W-1:0]       last_audio;
        logic signed [OFF_W-1:0] offset;
    } toc_reply_t;

    // Disc image, offset table and the replies the block still owes
    class toc_tracker;
        logic [CTRL_W-1:0]   ctrl_mem [TOC_SLOTS];
        logic [ADDR_W-1:0]   addr_mem [TOC_SLOTS];
        int                  offsets  [TOC_SLOTS];
        logic [SLOT_W-1:0]   first_audio;
        logic [SLOT_W-1:0]   last_audio;
        logic [STATUS_W-1:0] status;
        toc_reply_t          due_replies [$];
        int                  errors;
        int                  replies_checked;
        int                  n_loads;
        int                  n_reads;
        int                  n_evals;
        int                  n_evals_ok;

        function new();
            foreach (offsets[k]) begin
                ctrl_mem[k] = '0;
                addr_mem[k] = '0;
                offsets[k]  = 0;
            end
            first_audio     = '0;
            last_audio      = '0;
            status          = STATUS_OK;
            errors          = 0;
            replies_checked = 0;
            n_loads         = 0;
            n_reads         = 0;
            n_evals         = 0;
            n_evals_ok      = 0;
        endfunction

        // Start of the data session behind slot s, seen as a lead-out offset
        function int data_session_start(int s);
            return int'(addr_mem[s]) - XA_GAP + LEAD_IN;
        endfunction

        function void build_offsets(int first, int last);
            int s;
            int top;
            foreach (offsets[k]) offsets[k] = 0;
            first_audio = '0;
            last_audio  = '0;
            if (first < 1 || first >= TOC_SLOTS) begin
                status = STATUS_BAD_FIRST;
                return;
            end
            if (last < 1 || last >= TOC_SLOTS) begin
                status = STATUS_BAD_LAST;
                return;
            end
            // find the last audio track in range
            top = -1;
            for (s = first; s <= last; s++)
                if (!ctrl_mem[s][DATA_BIT]) top = s;
            if (top < 0) begin
                status = STATUS_NO_AUDIO;
                return;
            end
            for (s = first; s <= top; s++)
                offsets[s] = (addr_mem[s] != '0) ? int'(addr_mem[s]) + LEAD_IN : LEAD_IN;
            offsets[0] = (top < last) ? data_session_start(top + 1)
                                      : int'(addr_mem[0]) + LEAD_IN;
            // drop audio tracks that start past the lead-out
            while (top > 0 && offsets[0] < offsets[top]) begin
                top--;
                offsets[top + 1] = 0;
                offsets[0] = data_session_start(top + 1);
            end
            status      = STATUS_OK;
            first_audio = SLOT_W'(first);
            last_audio  = SLOT_W'(top);
        endfunction

        function void take_item(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                logic [CTRL_W-1:0] ctrl, logic [ADDR_W-1:0] addr,
                                logic [SLOT_W-1:0] first, logic [SLOT_W-1:0] last);
            toc_reply_t want;
            int         off;
            off = 0;
            case (func)
                FUNC_LOAD: begin
                    if (slot < TOC_SLOTS) begin
                        ctrl_mem[slot] = ctrl;
                        addr_mem[slot] = addr;
                        n_loads++;
                    end
                end
                FUNC_EVAL: begin
                    build_offsets(int'(first), int'(last));
                    n_evals++;
                    if (status == STATUS_OK) n_evals_ok++;
                end
                FUNC_READ: begin
                    n_reads++;
                    if (slot < TOC_SLOTS) off = offsets[slot];
                end
                default: ;
            endcase
            want.status      = status;
            want.first_audio = first_audio;
            want.last_audio  = last_audio;
            want.offset      = OFF_W'(off);
            due_replies.push_back(want);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] fa,
                                  logic [SLOT_W-1:0] la, logic [OFF_W-1:0] off);
            toc_reply_t want;
            replies_checked++;
            if (due_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Reply %0d arrived with none due: status %0d first %0d last %0d offset %0d",
                             replies_checked, st, fa, la, $signed(off));
                return;
            end
            want = due_replies.pop_front();
            if (st !== want.status || fa !== want.first_audio || la !== want.last_audio ||
                off !== want.offset) begin
                errors++;
                if (errors <= 10)
                    $display("Reply %0d wrong: expected status %0d first %0d last %0d offset %0d, got status %0d first %0d last %0d offset %0d",
                             replies_checked, want.status, want.first_audio, want.last_audio,
                             want.offset, st, fa, la, $signed(off));
            end
        endfunction
    endclass

endpackage

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdtoc_pkg::*;
    import tb_toc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 460;
    localparam int ADDR_MAX      = (1 << ADDR_W) - 1;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  i_ready         = 1'b0;
    logic [FUNC_W-1:0]     i_func          = '0;
    logic [SLOT_W-1:0]     i_slot          = '0;
    logic [CTRL_W-1:0]     i_control_bits  = '0;
    logic [ADDR_W-1:0]     i_start_address = '0;
    logic [SLOT_W-1:0]     i_first_track   = '0;
    logic [SLOT_W-1:0]     i_last_track    = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_W-1:0]     o_first_audio;
    logic [SLOT_W-1:0]     o_last_audio;
    logic signed [OFF_W-1:0] o_offset;

    toc_tracker tracker;
    bit         written [TOC_SLOTS];
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         cycle_count    = 0;
    int         items_sent     = 0;

    cd_toc_offset_builder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .i_control_bits  (i_control_bits),
        .i_start_address (i_start_address),
        .i_first_track   (i_first_track),
        .i_last_track    (i_last_track),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_first_audio   (o_first_audio),
        .o_last_audio    (o_last_audio),
        .o_offset        (o_offset)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Predict on every accepted item, check every accepted reply
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            tracker.take_item(i_func, i_slot, i_control_bits, i_start_address,
                              i_first_track, i_last_track);
        if (i_rst_n && o_valid && i_ready)
            tracker.check_reply(o_status, o_first_audio, o_last_audio, o_offset);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Hold one item on the input channel until it is taken
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic [CTRL_W-1:0] ctrl, input logic [ADDR_W-1:0] addr,
                             input logic [SLOT_W-1:0] first, input logic [SLOT_W-1:0] last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_slot          <= slot;
        i_control_bits  <= ctrl;
        i_start_address <= addr;
        i_first_track   <= first;
        i_last_track    <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!(func == FUNC_NONE || (func == FUNC_LOAD && slot >= TOC_SLOTS)))
            items_sent++;
    endtask

    task automatic load_entry(input int slot, input logic [CTRL_W-1:0] ctrl,
                              input logic [ADDR_W-1:0] addr);
        send_item(FUNC_LOAD, SLOT_W'(slot), ctrl, addr, SLOT_W'($urandom), SLOT_W'($urandom));
        if (slot < TOC_SLOTS) written[slot] = 1'b1;
    endtask

    task automatic evaluate_disc(input int first, input int last);
        send_item(FUNC_EVAL, SLOT_W'($urandom), CTRL_W'($urandom), ADDR_W'($urandom),
                  SLOT_W'(first), SLOT_W'(last));
    endtask

    task automatic read_slot(input int slot);
        send_item(FUNC_READ, SLOT_W'(slot), CTRL_W'($urandom), ADDR_W'($urandom),
                  SLOT_W'($urandom), SLOT_W'($urandom));
    endtask

    // Hold the input channel idle until every reply is in
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        read_slot(0);
        read_slot(127);
        send_item(FUNC_NONE, 7'd5, 4'hF, ADDR_W'(ADDR_MAX), 7'd1, 7'd1);
        // bad first and last track numbers, before any entry is loaded
        evaluate_disc(0, 5);
        evaluate_disc(127, 5);
        evaluate_disc(1, 0);
        evaluate_disc(1, TOC_SLOTS);
        load_entry(127, 4'hF, ADDR_W'(ADDR_MAX));
        load_entry(0, 4'h0, ADDR_W'(ADDR_MAX));
        load_entry(1, 4'h0, '0);
        load_entry(2, 4'h4, '0);
        load_entry(3, 4'hB, ADDR_W'(100000));
        // no audio in range, then first above last
        evaluate_disc(2, 2);
        evaluate_disc(3, 1);
        // data right after the only audio track drops it: lead-out at its lowest
        evaluate_disc(1, 2);
        read_slot(0);
        read_slot(1);
        // lead-out at its highest, zero address reads back as the lead-in
        evaluate_disc(1, 1);
        read_slot(0);
        read_slot(1);
        evaluate_disc(1, 3);
        read_slot(3);
        read_slot(TOC_SLOTS);
    endtask

    // Load a whole disc, evaluate it and read some offsets back
    task automatic play_disc();
        int first;
        int last;
        int s;
        int addr;
        int tail;
        int lead_addr;
        bit lead_early;
        logic [CTRL_W-1:0] ctrl;
        if ($urandom_range(99) < 4) begin
            last  = TOC_SLOTS - 1;
            first = ($urandom_range(3) == 0) ? last : $urandom_range(last, 1);
        end else begin
            first = ($urandom_range(99) < 70) ? 1 : $urandom_range(20, 1);
            last  = first + $urandom_range(11);
        end
        // fill holes below the first track: the drop walk may reach them
        for (s = 1; s < first; s++)
            if (!written[s]) load_entry(s, CTRL_W'($urandom), ADDR_W'($urandom));
        tail       = ($urandom_range(99) < 30) ? $urandom_range(2, 1) : 0;
        lead_early = $urandom_range(1);
        if (lead_early) load_entry(0, CTRL_W'($urandom), ADDR_W'($urandom));
        addr = ($urandom_range(3) == 0) ? 0 : $urandom_range(20000);
        for (s = first; s <= last; s++) begin
            ctrl           = CTRL_W'($urandom);
            ctrl[DATA_BIT] = (s > last - tail) || ($urandom_range(99) < 8);
            load_entry(s, ctrl, ADDR_W'(addr));
            addr = addr + $urandom_range(40000, 1);
            if (addr > ADDR_MAX) addr = ADDR_MAX;
        end
        if (!lead_early) begin
            lead_addr = ($urandom_range(99) < 70) ? addr + $urandom_range(5000)
                                                  : $urandom_range(ADDR_MAX);
            if (lead_addr > ADDR_MAX) lead_addr = ADDR_MAX;
            load_entry(0, CTRL_W'($urandom), ADDR_W'(lead_addr));
        end
        evaluate_disc(first, last);
        repeat ($urandom_range(6, 2))
            read_slot(($urandom_range(99) < 75) ? $urandom_range(last) : $urandom_range(127));
    endtask

    // Stray loads, reads, rejected evaluations and the unused code
    task automatic send_noise();
        int a;
        case ($urandom_range(4))
            0: load_entry($urandom_range(127), CTRL_W'($urandom), ADDR_W'($urandom));
            1: read_slot($urandom_range(127));
            2: begin
                case ($urandom_range(2))
                    0: evaluate_disc(($urandom_range(1) == 0) ? 0
                                         : $urandom_range(127, TOC_SLOTS),
                                     $urandom_range(127));
                    1: evaluate_disc($urandom_range(TOC_SLOTS - 1, 1),
                                     ($urandom_range(1) == 0) ? 0
                                         : $urandom_range(127, TOC_SLOTS));
                    default: begin
                        a = $urandom_range(TOC_SLOTS - 1, 2);
                        evaluate_disc(a, $urandom_range(a - 1, 1));
                    end
                endcase
            end
            3: send_item(FUNC_NONE, SLOT_W'($urandom), CTRL_W'($urandom), ADDR_W'($urandom),
                         SLOT_W'($urandom), SLOT_W'($urandom));
            default: read_slot($urandom_range(TOC_SLOTS - 1));
        endcase
    endtask

    initial begin
        int src_pcts  [4];
        int sink_pcts [4];
        int phase;
        int goal;
        src_pcts  = '{0, 80, 0, 24};
        sink_pcts = '{0, 0, 80, 24};
        tracker   = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            src_idle_pct   = src_pcts[phase];
            sink_stall_pct = sink_pcts[phase];
            if (phase == 0) run_directed();
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 80) play_disc();
                else repeat ($urandom_range(4, 1)) send_noise();
            end
            wait_drained();
        end

        // Let any late reply show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.errors += tracker.due_replies.size();

        $display("Covered %0d items in four flow-control phases: %0d loads, %0d reads, %0d evaluations (%0d built offsets).",
                 items_sent, tracker.n_loads, tracker.n_reads, tracker.n_evals,
                 tracker.n_evals_ok);
        $display("Checked %0d replies, %0d wrong or unexpected.",
                 tracker.replies_checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/cdtoc_pkg.sv
design/cd_toc_offset_builder_top.sv
design/cdtoc_checker.sv
bench/tb_top.sv
